FILE: src/glr_pkg.sv
`default_nettype none

package glr_pkg;

  // Storage word of the occupancy memory
  localparam int WORD_BITS = 64;
  localparam int WORD_LOG  = 6;

  // Operation codes
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result constants
  localparam logic [6:0] FORBIDDEN_VALUE = 7'd100;
  localparam logic [6:0] FREE_VALUE      = 7'd0;
  localparam logic [8:0] COUNT_LIMIT     = 9'd511;

  // Register map: index is paddr[2]
  localparam int         CFG_ADDR_W     = 3;
  localparam logic       CFG_IDX_WIDTH  = 1'b0;
  localparam logic       CFG_IDX_HEIGHT = 1'b1;
  localparam logic [8:0] MAP_SIZE_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         read_x;
    logic [7:0]         read_y;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cell_value;
    logic [8:0] cells_marked;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/grid_line_rasterizer.sv
`default_nettype none

// Line rasterizer over a one-bit occupancy grid held in one synchronous memory of
// 64-bit words (one write port, one registered read port). One item is worked at a
// time; a finished beat waits in the output register while the next item is taken.
// A draw passes the swap, order and init states, then walks one point per cycle
// along the major axis (|major delta| + 1 points, up to 65536 for the widest signed
// span, points off the grid included), then waits for the read-modify-write pipe to
// drain and posts the result; a forwarding path keeps back-to-back marks in one word
// at full rate. A read goes through the same address and memory pipe. A clear, and
// the clearing pass after reset, sweep the memory one word a cycle over all
// ceil(GRID_WIDTH_MAX * GRID_HEIGHT_MAX / 64) words, 1024 at the default size;
// in_stall stays high during the pass while register writes are taken as usual.
module grid_line_rasterizer
  import glr_pkg::*;
#(
  parameter int GRID_WIDTH_MAX  = 256,
  parameter int GRID_HEIGHT_MAX = 256
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output out_item_t             out_data,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [CFG_ADDR_W-1:0] paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CELL_COUNT = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
  localparam int DEPTH      = (CELL_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW         = IW + WORD_LOG;
  localparam int XW         = $clog2(GRID_WIDTH_MAX);
  localparam int YW         = $clog2(GRID_HEIGHT_MAX);
  localparam int WW         = $clog2(GRID_WIDTH_MAX + 1);
  localparam int HW         = $clog2(GRID_HEIGHT_MAX + 1);
  localparam logic [IW-1:0] LAST_WORD = IW'(DEPTH - 1);

  typedef enum logic [7:0] {
    ST_SWEEP = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SWAP  = 8'b0000_0100,
    ST_ORDER = 8'b0000_1000,
    ST_INIT  = 8'b0001_0000,
    ST_WALK  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [8:0] map_width_r, map_height_r;
  logic       cfg_wr;

  // Segment walker
  logic signed [15:0] ax_r, ay_r, bx_r, by_r;
  logic signed [15:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic               steep_r, steep_nxt;
  logic               yneg_r, yneg_nxt;
  logic [16:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [19:0] err_r, err_nxt;
  logic [8:0]         cnt_r, cnt_nxt;
  logic [6:0]         res_val_r, res_val_nxt;

  // Clearing sweep
  logic [IW-1:0] sweep_idx_r, sweep_idx_nxt;
  logic          sweep_item_r, sweep_item_nxt;

  // Address / memory pipe
  logic                 v1_r, v1_nxt, rd1_r, rd1_nxt;
  logic [XW-1:0]        gx1_r, gx1_nxt;
  logic [YW-1:0]        gy1_r, gy1_nxt;
  logic                 v2_r, rd2_r;
  logic [AW-1:0]        addr2_r;
  logic [IW-1:0]        idx2;
  logic                 v3_r, rd3_r, hit3_r;
  logic [IW-1:0]        idx3_r;
  logic [WORD_LOG-1:0]  bit3_r;
  logic [WORD_BITS-1:0] wprev_r, mem_rdata_r, base_word, merged_word;
  logic                 mem_we;
  logic [IW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WORD_BITS-1:0] mem [DEPTH];

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Combinational helpers
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic signed [16:0] diff_x, diff_y;
  logic [16:0]        abs_dx, abs_dy;
  logic signed [19:0] e1;
  logic signed [20:0] e1x2;
  logic               step_y;
  logic signed [15:0] walk_gx, walk_gy;
  logic               walk_in, walk_skip, walk_mark, walk_last;
  logic               rd_in;

  // Width and height in use, clamped to 1..max
  always_comb begin
    if (map_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(map_width_r) > 32'(GRID_WIDTH_MAX)) begin
      eff_w = WW'(GRID_WIDTH_MAX);
    end else begin
      eff_w = WW'(map_width_r);
    end
    if (map_height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(map_height_r) > 32'(GRID_HEIGHT_MAX)) begin
      eff_h = HW'(GRID_HEIGHT_MAX);
    end else begin
      eff_h = HW'(map_height_r);
    end
  end

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_IDX_HEIGHT) ? {23'b0, map_height_r}
                                               : {23'b0, map_width_r};

  // Endpoint deltas, shared by swap and init
  assign diff_x = {bx_r[15], bx_r} - {ax_r[15], ax_r};
  assign diff_y = {by_r[15], by_r} - {ay_r[15], ay_r};
  assign abs_dx = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign abs_dy = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);

  // One walk step: error update and point test
  assign e1        = err_r + signed'({3'b0, dy_r});
  assign e1x2      = {e1, 1'b0};
  assign step_y    = e1x2 >= signed'({4'b0, dx_r});
  assign walk_gx   = steep_r ? ay_r : ax_r;
  assign walk_gy   = steep_r ? ax_r : ay_r;
  assign walk_in   = !walk_gx[15] && !walk_gy[15] &&
                     (unsigned'(walk_gx) < 16'(eff_w)) &&
                     (unsigned'(walk_gy) < 16'(eff_h));
  assign walk_last = (ax_r == bx_r);
  assign walk_skip = walk_last && (ay_r == by_r);
  assign walk_mark = walk_in && !walk_skip;

  // Read cell inside the grid in use
  assign rd_in = (16'(in_data.read_x) < 16'(eff_w)) && (16'(in_data.read_y) < 16'(eff_h));

  // Word update at the write stage, forwarding the word written last cycle
  assign idx2        = addr2_r[AW-1:WORD_LOG];
  assign base_word   = hit3_r ? wprev_r : mem_rdata_r;
  assign merged_word = base_word | (WORD_BITS'(1) << bit3_r);
  assign mem_we      = (state_r == ST_SWEEP) || (v3_r && !rd3_r);
  assign mem_wa      = (state_r == ST_SWEEP) ? sweep_idx_r : idx3_r;
  assign mem_wd      = (state_r == ST_SWEEP) ? '0 : merged_word;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    steep_nxt      = steep_r;
    yneg_nxt       = yneg_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    err_nxt        = err_r;
    cnt_nxt        = cnt_r;
    res_val_nxt    = res_val_r;
    sweep_idx_nxt  = sweep_idx_r;
    sweep_item_nxt = sweep_item_r;
    v1_nxt         = 1'b0;
    rd1_nxt        = 1'b0;
    gx1_nxt        = gx1_r;
    gy1_nxt        = gy1_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    // Output beat taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Read data returns at the write stage
    if (v3_r && rd3_r) begin
      res_val_nxt = base_word[bit3_r] ? FORBIDDEN_VALUE : FREE_VALUE;
    end

    unique case (state_r)
      ST_SWEEP: begin
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == LAST_WORD) begin
          sweep_idx_nxt = '0;
          state_nxt     = sweep_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt     = '0;
          res_val_nxt = FREE_VALUE;
          unique case (in_data.func)
            FUNC_DRAW: begin
              ax_nxt    = in_data.start_x;
              ay_nxt    = in_data.start_y;
              bx_nxt    = in_data.end_x;
              by_nxt    = in_data.end_y;
              state_nxt = ST_SWAP;
            end
            FUNC_READ: begin
              if (rd_in) begin
                v1_nxt    = 1'b1;
                rd1_nxt   = 1'b1;
                gx1_nxt   = XW'(in_data.read_x);
                gy1_nxt   = YW'(in_data.read_y);
                state_nxt = ST_DRAIN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FUNC_CLEAR: begin
              sweep_item_nxt = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SWAP: begin
        // steep lines walk along y
        steep_nxt = abs_dy > abs_dx;
        if (abs_dy > abs_dx) begin
          ax_nxt = ay_r;
          ay_nxt = ax_r;
          bx_nxt = by_r;
          by_nxt = bx_r;
        end
        state_nxt = ST_ORDER;
      end
      ST_ORDER: begin
        if (ax_r > bx_r) begin
          ax_nxt = bx_r;
          ay_nxt = by_r;
          bx_nxt = ax_r;
          by_nxt = ay_r;
        end
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        dx_nxt    = 17'(diff_x);
        dy_nxt    = abs_dy;
        yneg_nxt  = !(ay_r < by_r);
        err_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        v1_nxt  = walk_mark;
        gx1_nxt = XW'(unsigned'(walk_gx));
        gy1_nxt = YW'(unsigned'(walk_gy));
        if (walk_mark && (cnt_r != COUNT_LIMIT)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (step_y) begin
          err_nxt = e1 - signed'({3'b0, dx_r});
          ay_nxt  = yneg_r ? ay_r - 16'sd1 : ay_r + 16'sd1;
        end else begin
          err_nxt = e1;
        end
        if (walk_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          ax_nxt = ax_r + 16'sd1;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.cell_value   = res_val_r;
          out_data_nxt.cells_marked = cnt_r;
          sweep_item_nxt            = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_idx_r  <= '0;
      sweep_item_r <= 1'b0;
      map_width_r  <= MAP_SIZE_RESET;
      map_height_r <= MAP_SIZE_RESET;
      out_valid_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      hit3_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_idx_r  <= sweep_idx_nxt;
      sweep_item_r <= sweep_item_nxt;
      out_valid_r  <= out_valid_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      hit3_r       <= v2_r && v3_r && !rd3_r && (idx2 == idx3_r);
      if (cfg_wr && (paddr[2] == CFG_IDX_WIDTH)) begin
        map_width_r <= pwdata[8:0];
      end
      if (cfg_wr && (paddr[2] == CFG_IDX_HEIGHT)) begin
        map_height_r <= pwdata[8:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    steep_r    <= steep_nxt;
    yneg_r     <= yneg_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    err_r      <= err_nxt;
    cnt_r      <= cnt_nxt;
    res_val_r  <= res_val_nxt;
    out_data_r <= out_data_nxt;
    // address stage: cell index x + y*width
    rd1_r      <= rd1_nxt;
    gx1_r      <= gx1_nxt;
    gy1_r      <= gy1_nxt;
    rd2_r      <= rd1_r;
    addr2_r    <= AW'(gx1_r) + AW'(gy1_r) * AW'(eff_w);
    // read stage
    rd3_r      <= rd2_r;
    idx3_r     <= idx2;
    bit3_r     <= addr2_r[WORD_LOG-1:0];
    wprev_r    <= merged_word;
  end

  // Occupancy memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rdata_r <= mem[idx2];
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // no pipeline mark may collide with the clearing sweep on the write port
  a_sweep_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !(v3_r && !rd3_r))
    else $error("mark write during clearing sweep");

  // a result is posted only after all writes of the item are done
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !(v1_r || v2_r || v3_r))
    else $error("result posted with pipe not drained");

  // forwarding only follows a mark write in the previous cycle
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    hit3_r |-> $past(v3_r && !rd3_r))
    else $error("forward hit without a preceding write");

  // one item at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while item in work");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_grid_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_grid_line_rasterizer;
  import glr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         GRID_MAX    = 256;
  localparam int         CELLS       = GRID_MAX * GRID_MAX;
  localparam int         PHASES      = 9;
  localparam int         PHASE_OPS   = 170;

  // DUT ports
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  grid_line_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the occupancy store and the map size registers
  bit         occ_grid [0:CELLS-1];
  logic [8:0] map_w = MAP_SIZE_RESET;
  logic [8:0] map_h = MAP_SIZE_RESET;

  in_item_t  op_backlog [$];
  out_item_t grid_replies [$];

  bit          beat_taken;
  int          send_idle_pct, recv_idle_pct;
  int          err_cnt, cycle_cnt;
  int          cycle_budget = 4000;
  int          seg_x0, seg_y0, seg_x1, seg_y1;
  int          n_draw, n_read, n_read_hit, n_clear, n_nop, cells_total;

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // zero reads as one, anything past the grid size reads as the max
  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic int plot_cell(int px, int py, int w, int h);
    if (px < 0 || py < 0 || px >= w || py >= h) return 0;
    occ_grid[px + py * w] = 1'b1;
    return 1;
  endfunction

  // Bresenham walk; the final point in traversal order is never plotted
  function automatic logic [8:0] walk_segment(int ax, int ay, int bx, int by);
    int w, h, t, dx, dy, err, ystep, x, y, cx, cy, count;
    bit steep;
    w     = eff_dim(map_w);
    h     = eff_dim(map_h);
    count = 0;
    steep = iabs(by - ay) > iabs(bx - ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx    = bx - ax;
    dy    = iabs(by - ay);
    err   = 0;
    ystep = (ay < by) ? 1 : -1;
    y     = ay;
    for (x = ax; x <= bx; x++) begin
      cx = x;
      cy = y;
      err += dy;
      if (2 * err >= dx) begin
        y   += ystep;
        err -= dx;
      end
      if (!(cx == bx && cy == by)) begin
        count += steep ? plot_cell(cy, cx, w, h) : plot_cell(cx, cy, w, h);
        if (count > COUNT_LIMIT) count = COUNT_LIMIT;
      end
    end
    return count[8:0];
  endfunction

  // Expected reply for one operation, updating the shadow store
  function automatic out_item_t rasterize_op(in_item_t op);
    out_item_t res;
    int w, h, rx, ry;
    res = '0;
    w   = eff_dim(map_w);
    h   = eff_dim(map_h);
    case (op.func)
      FUNC_DRAW: begin
        res.cells_marked = walk_segment($signed(op.start_x), $signed(op.start_y),
                                        $signed(op.end_x), $signed(op.end_y));
        n_draw++;
        cells_total += int'(res.cells_marked);
      end
      FUNC_READ: begin
        rx = int'(op.read_x);
        ry = int'(op.read_y);
        n_read++;
        if (rx < w && ry < h && occ_grid[rx + ry * w]) begin
          res.cell_value = FORBIDDEN_VALUE;
          n_read_hit++;
        end else begin
          res.cell_value = FREE_VALUE;
        end
      end
      FUNC_CLEAR: begin
        foreach (occ_grid[k]) occ_grid[k] = 1'b0;
        n_clear++;
      end
      default: n_nop++;
    endcase
    return res;
  endfunction

  // Random operation: mostly segments near the grid and reads along them
  function automatic in_item_t rand_op();
    in_item_t op;
    int w, h, c, sx, sy, ex, ey, t;
    w          = eff_dim(map_w);
    h          = eff_dim(map_h);
    op.start_x = 16'($urandom());
    op.start_y = 16'($urandom());
    op.end_x   = 16'($urandom());
    op.end_y   = 16'($urandom());
    op.read_x  = 8'($urandom());
    op.read_y  = 8'($urandom());
    c = $urandom_range(99);
    if (c < 55)      op.func = FUNC_DRAW;
    else if (c < 93) op.func = FUNC_READ;
    else if (c < 97) op.func = FUNC_CLEAR;
    else             op.func = FUNC_UNUSED;
    c = $urandom_range(999);
    // c < 3 on a draw keeps the full-range endpoints
    if (op.func == FUNC_DRAW && c >= 3) begin
      if (c < 60) begin
        // short segment anywhere in the signed range
        sx = $signed(op.start_x);
        sy = $signed(op.start_y);
        ex = clampi(sx + int'($urandom_range(80)) - 40, -32768, 32767);
        ey = clampi(sy + int'($urandom_range(80)) - 40, -32768, 32767);
      end else begin
        sx = int'($urandom_range(w + 11)) - 6;
        sy = int'($urandom_range(h + 11)) - 6;
        ex = int'($urandom_range(w + 11)) - 6;
        ey = int'($urandom_range(h + 11)) - 6;
        if (c % 10 == 0)      ey = sy;
        else if (c % 10 == 1) ex = sx;
        else if (c % 25 == 2) begin
          ex = sx;
          ey = sy;
        end
        seg_x0 = sx; seg_y0 = sy; seg_x1 = ex; seg_y1 = ey;
      end
      op.start_x = 16'(sx);
      op.start_y = 16'(sy);
      op.end_x   = 16'(ex);
      op.end_y   = 16'(ey);
    end else if (op.func == FUNC_READ && c < 800) begin
      if (c < 500) begin
        // probe on or next to the last near-grid segment
        t = $urandom_range(16);
        op.read_x = 8'(clampi(seg_x0 + (seg_x1 - seg_x0) * t / 16
                              + int'($urandom_range(2)) - 1, 0, 255));
        op.read_y = 8'(clampi(seg_y0 + (seg_y1 - seg_y0) * t / 16
                              + int'($urandom_range(2)) - 1, 0, 255));
      end else begin
        op.read_x = 8'($urandom_range(w - 1));
        op.read_y = 8'($urandom_range(h - 1));
      end
    end
    return op;
  endfunction

  task automatic queue_op(in_item_t op);
    int span;
    span = 0;
    if (op.func == FUNC_DRAW) begin
      span = iabs($signed(op.end_x) - $signed(op.start_x));
      if (iabs($signed(op.end_y) - $signed(op.start_y)) > span)
        span = iabs($signed(op.end_y) - $signed(op.start_y));
    end else if (op.func == FUNC_CLEAR) begin
      span = 1100;
    end
    cycle_budget += span + 80;
    op_backlog.insert(op_backlog.size(), op);
  endtask

  task automatic push_op(logic [1:0] f, int sx, int sy, int ex, int ey, int rx, int ry);
    in_item_t op;
    op.func    = f;
    op.start_x = 16'(sx);
    op.start_y = 16'(sy);
    op.end_x   = 16'(ex);
    op.end_y   = 16'(ey);
    op.read_x  = 8'(rx);
    op.read_y  = 8'(ry);
    queue_op(op);
  endtask

  // Register write followed by a read back of the same register
  task automatic cfg_set(logic idx, logic [8:0] val);
    logic [22:0] junk;
    junk = 23'($urandom());
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = {junk, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_IDX_WIDTH) map_w = val;
    else                      map_h = val;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[8:0] !== val) begin
      $error("register %0d: expected %0d, got %0d", idx, val, prdata[8:0]);
      err_cnt++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    cycle_budget += 20;
  endtask

  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid || grid_replies.size() != 0)
      @(posedge clk);
  endtask

  // Monitor: check result beats, then predict for the accepted input beat
  always @(posedge clk) begin : beat_check
    out_item_t want;
    beat_taken = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (grid_replies.size() == 0) begin
        $error("result beat with no operation outstanding");
        err_cnt++;
      end else begin
        want = grid_replies.pop_front();
        if (out_data.cell_value !== want.cell_value) begin
          $error("cell_value: expected %0d, got %0d", want.cell_value, out_data.cell_value);
          err_cnt++;
        end
        if (out_data.cells_marked !== want.cells_marked) begin
          $error("cells_marked: expected %0d, got %0d",
                 want.cells_marked, out_data.cells_marked);
          err_cnt++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      grid_replies.insert(grid_replies.size(), rasterize_op(in_data));
      beat_taken = 1'b1;
    end
  end

  // Driver: next beat or a gap once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || beat_taken) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= op_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 4 * cycle_budget) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stim
    int p, i;
    logic [8:0] widths  [PHASES];
    logic [8:0] heights [PHASES];
    widths  = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd256, 9'd16, 9'd300, 9'd37, 9'd3};
    heights = '{9'd256, 9'd0, 9'd300, 9'd256, 9'd1, 9'd12, 9'd7, 9'd180, 9'd2};
    send_idle_pct = 13;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (p = 0; p < PHASES; p++) begin
      // idling profile: sender light, then receiver light, then none
      case (p / 3)
        0: begin send_idle_pct = 13; recv_idle_pct = 64; end
        1: begin send_idle_pct = 64; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_drained();
      cfg_set(CFG_IDX_WIDTH, widths[p]);
      cfg_set(CFG_IDX_HEIGHT, heights[p]);

      if (p == 0) begin
        // directed: endpoint skip, ordering, steep walks, clipping, extremes
        push_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_DRAW, 0, 0, 10, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 9, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 10, 0);
        push_op(FUNC_DRAW, 20, 5, 10, 5, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 20, 5);
        push_op(FUNC_READ, 0, 0, 0, 0, 10, 5);
        push_op(FUNC_DRAW, 3, 0, 4, 20, 0, 0);
        push_op(FUNC_DRAW, 50, 40, 45, 10, 0, 0);
        push_op(FUNC_DRAW, 7, 7, 7, 7, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 7, 7);
        push_op(FUNC_DRAW, 0, 0, 4, 2, 0, 0);
        push_op(FUNC_DRAW, -5, -5, 300, 300, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 255, 255);
        push_op(FUNC_DRAW, -32768, -32768, 32767, 32767, 0, 0);
        push_op(FUNC_DRAW, 32767, -32768, -32768, 32767, 0, 0);
        push_op(FUNC_DRAW, 255, -32768, 255, 32767, 0, 0);
        push_op(FUNC_UNUSED, -1, -1, -1, -1, 255, 255);
        push_op(FUNC_READ, 0, 0, 0, 0, 255, 128);
        push_op(FUNC_READ, 0, 0, 0, 0, 128, 128);
        push_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_READ, 0, 0, 0, 0, 255, 128);
        wait_drained();
      end

      for (i = 0; i < PHASE_OPS; i++) begin
        // mid-phase the sender holds off until every reply is back
        if (i == PHASE_OPS / 2) wait_drained();
        queue_op(rand_op());
      end
    end

    wait_drained();
    repeat (32) @(posedge clk);
    $display("Covered %0d draws marking %0d cells, %0d reads (%0d forbidden), %0d clears,",
             n_draw, cells_total, n_read, n_read_hit, n_clear);
    $display("%0d unused-func ops across %0d map sizes in %0d cycles",
             n_nop, PHASES, cycle_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
